/* rtl/ibar_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the attribute renderer.
`default_nettype none
package ibar_pkg;

   localparam int BAND_ROWS    = 24;
   localparam int FLASH_FRAMES = 16;
   localparam int FLASH_W      = $clog2(FLASH_FRAMES + 1);

   localparam int BITMAP_DEPTH = 6144;
   localparam int ATTR_DEPTH   = 768;
   localparam int BITMAP_AW    = 13;
   localparam int ATTR_AW      = 10;
   localparam int NUM_COLS     = 32;
   localparam int COL_W        = 5;
   localparam int PICTURE_ROWS = 192;

   localparam logic [15:0] VMEM_BASE = 16'h4000;
   localparam logic [15:0] VMEM_LAST = 16'h5AFF;

   localparam int REQ_W = 40;
   localparam int RSP_W = 48;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_RENDER = 2'd1,
      OP_FRAME  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef struct packed {
      logic                 write;
      logic                 frame;
      logic                 load_row;
      logic                 issue;
      logic [COL_W-1:0]     col;
      logic                 last;
      logic                 clear;
      logic [BITMAP_AW-1:0] clear_idx;
   } cmd_type;

   typedef struct packed {
      logic slot_free;
   } stat_type;

   function automatic logic [2:0] band_of(input logic [7:0] y);
      logic [2:0] band;
      band = 3'd0;
      for (int b = 1; b < 8; b++) begin
         if (int'(y) >= b * BAND_ROWS) begin
            band = 3'(b);
         end
      end
      return band;
   endfunction

endpackage
`default_nettype wire

/* rtl/ibar_ctrl.sv */
// Controller: memory clearing pass, item acceptance and column sequencing of a row render.
`default_nettype none
module ibar_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [1:0]        req_op,
   input  wire ibar_pkg::stat_type stat,
   output ibar_pkg::cmd_type      cmd
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RENDER
   } state_type;

   state_type                      state_ff, state_in;
   logic [ibar_pkg::BITMAP_AW-1:0] clr_idx_ff, clr_idx_in;
   logic [ibar_pkg::COL_W-1:0]     col_ff, col_in;
   ibar_pkg::op_type               op;

   assign op = ibar_pkg::op_type'(req_op);

   always_comb begin
      state_in   = state_ff;
      clr_idx_in = clr_idx_ff;
      col_in     = col_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear     = 1'b1;
            cmd.clear_idx = clr_idx_ff;
            clr_idx_in    = clr_idx_ff + 1'b1;
            if (clr_idx_ff == ibar_pkg::BITMAP_AW'(ibar_pkg::BITMAP_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = stat.slot_free;
            if (req_tvalid && stat.slot_free) begin
               unique case (op)
                  ibar_pkg::OP_WRITE: begin
                     cmd.write = 1'b1;
                  end
                  ibar_pkg::OP_RENDER: begin
                     cmd.load_row = 1'b1;
                     col_in       = '0;
                     state_in     = ST_RENDER;
                  end
                  ibar_pkg::OP_FRAME: begin
                     cmd.frame = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RENDER: begin
            if (stat.slot_free) begin
               cmd.issue = 1'b1;
               cmd.col   = col_ff;
               cmd.last  = (col_ff == ibar_pkg::COL_W'(ibar_pkg::NUM_COLS - 1));
               col_in    = col_ff + 1'b1;
               if (cmd.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_idx_ff <= '0;
         col_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         clr_idx_ff <= clr_idx_in;
         col_ff     <= col_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/ibar_datapath.sv */
// Datapath: video memories, band marks, flash state, read stage and result register.
`default_nettype none
module ibar_datapath (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire ibar_pkg::cmd_type          cmd,
   output ibar_pkg::stat_type              stat,
   input  wire logic [ibar_pkg::REQ_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [ibar_pkg::RSP_W-1:0]      rsp_tdata,
   output logic                            rsp_tlast
);

   logic [7:0] bitmap_mem [ibar_pkg::BITMAP_DEPTH];
   logic [7:0] attr_mem   [ibar_pkg::ATTR_DEPTH];

   logic [15:0] wr_addr;
   logic [7:0]  wr_data;
   logic [7:0]  req_row;
   logic        wr_in_range;
   logic [15:0] wr_off_full;
   logic [ibar_pkg::BITMAP_AW-1:0] wr_off;
   logic        wr_bitmap;
   logic [ibar_pkg::ATTR_AW-1:0] wr_aoff;
   logic [7:0]  wr_y, wr_y0, wr_y1;
   logic [7:0]  wr_marks;

   logic [7:0]  band_marks_ff, band_marks_in;
   logic [ibar_pkg::FLASH_W-1:0] flash_count_ff, flash_count_in;
   logic        flash_phase_ff, flash_phase_in;

   logic [7:0]  row_ff;
   logic        row_blank;
   logic [ibar_pkg::BITMAP_AW-1:0] rd_baddr;
   logic [ibar_pkg::ATTR_AW-1:0]   rd_aaddr;

   logic        rd_valid_ff;
   logic        rd_frame_ff;
   logic        rd_blank_ff;
   logic        rd_band_ff;
   logic        rd_flash_ff;
   logic        rd_last_ff;
   logic [ibar_pkg::COL_W-1:0] rd_col_ff;
   logic [7:0]  rd_mask_ff;
   logic [7:0]  bits_ff;
   logic [7:0]  attr_ff;

   logic        out_free;
   logic [3:0]  ink, pap;
   logic [31:0] pix;

   logic        rsp_valid_ff;
   logic [ibar_pkg::COL_W-1:0] rsp_col_ff;
   logic [31:0] rsp_pix_ff;
   logic        rsp_bd_ff;
   logic [7:0]  rsp_mask_ff;
   logic        rsp_last_ff;

   assign wr_addr = req_tdata[17:2];
   assign wr_data = req_tdata[25:18];
   assign req_row = req_tdata[33:26];

   assign wr_in_range = (wr_addr >= ibar_pkg::VMEM_BASE) && (wr_addr <= ibar_pkg::VMEM_LAST);
   assign wr_off_full = wr_addr - ibar_pkg::VMEM_BASE;
   assign wr_off      = wr_off_full[ibar_pkg::BITMAP_AW-1:0];
   assign wr_bitmap   = wr_off < ibar_pkg::BITMAP_AW'(ibar_pkg::BITMAP_DEPTH);
   assign wr_aoff     = ibar_pkg::ATTR_AW'(wr_off - ibar_pkg::BITMAP_AW'(ibar_pkg::BITMAP_DEPTH));
   assign wr_y        = {wr_off[12:11], wr_off[7:5], wr_off[10:8]};
   assign wr_y0       = {wr_aoff[9:5], 3'b000};
   assign wr_y1       = {wr_aoff[9:5], 3'b111};

   always_comb begin
      if (wr_bitmap) begin
         wr_marks = 8'd1 << ibar_pkg::band_of(wr_y);
      end else begin
         wr_marks = (8'd1 << ibar_pkg::band_of(wr_y0)) | (8'd1 << ibar_pkg::band_of(wr_y1));
      end
   end

   // mark on writes; report, clear (or set all when the flash phase toggles) and count on frame items
   always_comb begin
      band_marks_in  = band_marks_ff;
      flash_count_in = flash_count_ff;
      flash_phase_in = flash_phase_ff;
      if (cmd.write && wr_in_range) begin
         band_marks_in = band_marks_ff | wr_marks;
      end else if (cmd.frame) begin
         if (flash_count_ff == ibar_pkg::FLASH_W'(ibar_pkg::FLASH_FRAMES - 1)) begin
            flash_count_in = '0;
            flash_phase_in = ~flash_phase_ff;
            band_marks_in  = 8'hFF;
         end else begin
            flash_count_in = flash_count_ff + 1'b1;
            band_marks_in  = 8'h00;
         end
      end
   end

   assign row_blank = row_ff >= 8'(ibar_pkg::PICTURE_ROWS);
   assign rd_baddr  = {row_ff[7:6], row_ff[2:0], row_ff[5:3], cmd.col};
   assign rd_aaddr  = {row_ff[7:3], cmd.col};

   assign out_free       = !rsp_valid_ff || rsp_tready;
   assign stat.slot_free = !rd_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         bitmap_mem[cmd.clear_idx] <= '0;
         if (cmd.clear_idx < ibar_pkg::BITMAP_AW'(ibar_pkg::ATTR_DEPTH)) begin
            attr_mem[cmd.clear_idx[ibar_pkg::ATTR_AW-1:0]] <= '0;
         end
      end else if (cmd.write && wr_in_range) begin
         if (wr_bitmap) begin
            bitmap_mem[wr_off] <= wr_data;
         end else begin
            attr_mem[wr_aoff] <= wr_data;
         end
      end
      if (cmd.issue && !row_blank) begin
         bits_ff <= bitmap_mem[rd_baddr];
         attr_ff <= attr_mem[rd_aaddr];
      end
   end

   always_comb begin
      ink = {attr_ff[6], attr_ff[2:0]};
      pap = {attr_ff[6], attr_ff[5:3]};
      if (attr_ff[7] && rd_flash_ff) begin
         ink = {attr_ff[6], attr_ff[5:3]};
         pap = {attr_ff[6], attr_ff[2:0]};
      end
      for (int i = 0; i < 8; i++) begin
         pix[31 - 4*i -: 4] = bits_ff[7 - i] ? ink : pap;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         band_marks_ff  <= 8'hFF;
         flash_count_ff <= '0;
         flash_phase_ff <= 1'b0;
         rd_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         band_marks_ff  <= band_marks_in;
         flash_count_ff <= flash_count_in;
         flash_phase_ff <= flash_phase_in;
         if (cmd.issue || cmd.frame) begin
            rd_valid_ff <= 1'b1;
         end else if (out_free) begin
            rd_valid_ff <= 1'b0;
         end
         if (out_free) begin
            rsp_valid_ff <= rd_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_row) begin
         row_ff <= req_row;
      end
      if (cmd.issue) begin
         rd_frame_ff <= 1'b0;
         rd_blank_ff <= row_blank;
         rd_band_ff  <= band_marks_ff[ibar_pkg::band_of(row_ff)];
         rd_flash_ff <= flash_phase_ff;
         rd_last_ff  <= cmd.last;
         rd_col_ff   <= cmd.col;
         rd_mask_ff  <= 8'h00;
      end else if (cmd.frame) begin
         rd_frame_ff <= 1'b1;
         rd_blank_ff <= 1'b1;
         rd_band_ff  <= 1'b0;
         rd_flash_ff <= 1'b0;
         rd_last_ff  <= 1'b1;
         rd_col_ff   <= '0;
         rd_mask_ff  <= band_marks_ff;
      end
      if (rd_valid_ff && out_free) begin
         rsp_col_ff  <= rd_col_ff;
         rsp_pix_ff  <= rd_blank_ff ? 32'd0 : pix;
         rsp_bd_ff   <= rd_band_ff && !rd_blank_ff;
         rsp_mask_ff <= rd_frame_ff ? rd_mask_ff : 8'h00;
         rsp_last_ff <= rd_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_mask_ff, rsp_bd_ff, rsp_pix_ff, rsp_col_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

/* rtl/interleaved_bitmap_attribute_renderer.sv */
// Top level of the interleaved bitmap and attribute renderer.
//
// Input items arrive on req_* and carry an op: memory write, pixel row render or end of frame.
// Results leave on rsp_*; rsp_tlast marks the final result of each input item.
// A write gives no result. A frame item gives one result with the band dirty mask.
// A row render is accepted and then issues one column per cycle, while the read stage and
// result register have room, for 32 columns, set by the single read port pair of the bitmap
// and attribute memories. Each column passes through the read stage, then the result register.
// After reset the block clears video memory, one bitmap byte per cycle (and one attribute
// byte while the index is below 768), with req_tready low; band marks reset to all ones.
// A result register and a read stage sit between the memories and rsp_*; when the receiver
// stalls, the render pauses column by column and no result is lost.
`default_nettype none
module interleaved_bitmap_attribute_renderer (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   // op[1:0], address[17:2], data[25:18], row[33:26], zero fill
   input  wire logic [ibar_pkg::REQ_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   // column[4:0], pixels[36:5], band_dirty[37], dirty_mask[45:38], zero fill
   output logic [ibar_pkg::RSP_W-1:0]      rsp_tdata,
   output logic                            rsp_tlast
);

   ibar_pkg::cmd_type  cmd;
   ibar_pkg::stat_type stat;

   ibar_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tdata[1:0]),
      .stat       (stat),
      .cmd        (cmd)
   );

   ibar_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire
